// File: hdl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// No dependencies; imported by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = TBL_AW + 1;
    localparam int REC_W       = 64;

    // Field widths fixed by the interface
    localparam int SLOT_W  = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;
    localparam int BONUS_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Reset values and limits
    localparam logic [COUNT_W-1:0] COUNT_RESET = '0;
    localparam logic [BONUS_W-1:0] BONUS_RESET = 16'd100;
    localparam logic signed [DATA_W:0] SCORE_MAX = 33'sh0_7FFF_FFFF;

    // Request action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BONUS_AMOUNT = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: hdl/stbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the record table of the search block.
`timescale 1ns / 1ps
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry through the registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/sorted_table_binary_search.sv
// Sorted table binary search: record table in one stbs_ram, controller on top (stbs_pkg).
// A load is written when it is accepted; a search probes the table once per step, at most
// log2(TABLE_DEPTH)+1 probes. Either request then passes the done state into the output register.
// One request in flight: the next is taken only after the result has entered the output
// register, which waits while the previous result there is stalled.
// Reset (i_rst_n low, synchronous) clears control, sets count 0 and bonus 100; table not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration write port
    input  wire                              i_cfg_wr_en,
    input  wire [stbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [stbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_action,
    input  wire [stbs_pkg::SLOT_W-1:0]       i_slot,
    input  wire signed [stbs_pkg::DATA_W-1:0] i_entry_id,
    input  wire signed [stbs_pkg::DATA_W-1:0] i_entry_score,
    input  wire signed [stbs_pkg::DATA_W-1:0] i_search_id,
    // result channel
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic                             o_found,
    output logic [stbs_pkg::SLOT_W-1:0]      o_found_slot,
    output logic signed [stbs_pkg::DATA_W-1:0] o_new_score
);

    import stbs_pkg::*;

    // Control and config registers
    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_entry_count;
    logic [BONUS_W-1:0]   r_bonus;

    // Search registers
    logic signed [DATA_W-1:0] r_key;
    logic [BOUND_W-1:0]   r_lo, n_lo;
    logic [BOUND_W-1:0]   r_hi, n_hi;
    logic [TBL_AW-1:0]    r_mid, n_mid;

    // Pending result
    logic                 r_res_found;
    logic [SLOT_W-1:0]    r_res_slot;
    logic signed [DATA_W-1:0] r_res_score;

    // Output register
    logic                 r_out_valid;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_found_slot;
    logic signed [DATA_W-1:0] r_new_score;

    // RAM ports
    logic                 ram_we;
    logic [TBL_AW-1:0]    ram_waddr;
    logic [REC_W-1:0]     ram_wdata;
    logic [TBL_AW-1:0]    ram_raddr;
    logic [REC_W-1:0]     ram_rdata;

    // Datapath helpers
    logic                 accept;
    logic                 out_free;
    logic                 slot_in_range;
    logic [BOUND_W-1:0]   count_clamp;
    logic [BOUND_W-1:0]   lo_sel, hi_sel;
    logic [BOUND_W:0]     mid_sum;
    logic                 range_empty;
    logic signed [DATA_W-1:0] rd_id;
    logic signed [DATA_W-1:0] rd_score;
    logic                 hit;
    logic                 probe_lt;
    logic signed [DATA_W:0] score_sum;
    logic signed [DATA_W-1:0] score_sat;

    stbs_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Clamp the searched count to the table depth
    assign count_clamp = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ?
                         BOUND_W'(TABLE_DEPTH) : BOUND_W'(r_entry_count);
    assign slot_in_range = 32'(i_slot) < 32'(TABLE_DEPTH);

    // Compare the probed record against the key
    assign rd_id    = $signed(ram_rdata[REC_W-1:DATA_W]);
    assign rd_score = $signed(ram_rdata[DATA_W-1:0]);
    assign hit      = (rd_id == r_key);
    assign probe_lt = (rd_id < r_key);

    // Add the bonus, saturate at the positive limit
    assign score_sum = $signed({rd_score[DATA_W-1], rd_score})
                     + $signed({{(DATA_W+1-BONUS_W){1'b0}}, r_bonus});
    assign score_sat = (score_sum > SCORE_MAX) ? SCORE_MAX[DATA_W-1:0]
                                                : score_sum[DATA_W-1:0];

    // Narrow the range: start a new search or step after a probe
    always_comb begin
        if (r_state == ST_IDLE) begin
            lo_sel = '0;
            hi_sel = count_clamp;
        end else if (probe_lt) begin
            lo_sel = BOUND_W'(r_mid) + BOUND_W'(1);
            hi_sel = r_hi;
        end else begin
            lo_sel = r_lo;
            hi_sel = BOUND_W'(r_mid);
        end
        range_empty = (lo_sel >= hi_sel);
        mid_sum     = {1'b0, lo_sel} + {1'b0, hi_sel} - (BOUND_W+1)'(1);
        n_lo        = lo_sel;
        n_hi        = hi_sel;
        n_mid       = mid_sum[TBL_AW:1];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_SEARCH && !range_empty) begin
                        n_state = ST_PROBE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PROBE: begin
                if (hit || range_empty) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake and RAM control
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_mid;
        ram_wdata  = {rd_id, score_sat};
        ram_raddr  = n_mid;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                ram_waddr  = TBL_AW'(i_slot);
                ram_wdata  = {i_entry_id, i_entry_score};
                ram_we     = accept && (i_action == ACT_LOAD) && slot_in_range;
            end
            ST_PROBE: begin
                ram_we = hit;
            end
            ST_DONE: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_entry_count <= COUNT_RESET;
            r_bonus       <= BONUS_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ENTRY_COUNT:  r_entry_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_BONUS_AMOUNT: r_bonus       <= i_cfg_data[BONUS_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Search and result registers
    always_ff @(posedge i_clk) begin
        // start a request: clear the pending result, capture the key
        if (r_state == ST_IDLE && accept) begin
            r_key       <= i_search_id;
            r_res_found <= 1'b0;
            r_res_slot  <= '0;
            r_res_score <= '0;
        end
        // advance the search bounds and the probe address
        if (r_state == ST_IDLE || r_state == ST_PROBE) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_mid <= n_mid;
        end
        // hold the hit result
        if (r_state == ST_PROBE && hit) begin
            r_res_found <= 1'b1;
            r_res_slot  <= SLOT_W'(r_mid);
            r_res_score <= score_sat;
        end
        // move the result into the output register
        if (r_state == ST_DONE && out_free) begin
            r_found      <= r_res_found;
            r_found_slot <= r_res_slot;
            r_new_score  <= r_res_score;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_found_slot = r_found_slot;
    assign o_new_score  = r_new_score;

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for sorted_table_binary_search: table loads, searches, score bonus.
// Uses stbs_pkg for widths and codes; predicts all but typed rows from its own table copy.
`timescale 1ns / 1ps

module tb;
    import stbs_pkg::*;

    localparam logic [DATA_W-1:0] ID_MIN    = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ID_MAX    = 32'h7FFF_FFFF;
    localparam longint            SCORE_TOP = 2147483647;
    localparam int                PHASES    = 11;
    localparam int                PHASE_REQS = 140;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] entry_id;
        logic [DATA_W-1:0] entry_score;
        logic [DATA_W-1:0] search_id;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] score;
    } t_res;

    typedef enum logic {ROW_CFG, ROW_REQ} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
        t_req                 req;
        logic                 typed;
        t_res                 want;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_action;
    logic [SLOT_W-1:0]      i_slot;
    logic [DATA_W-1:0]      i_entry_id;
    logic [DATA_W-1:0]      i_entry_score;
    logic [DATA_W-1:0]      i_search_id;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_found;
    logic [SLOT_W-1:0]      o_found_slot;
    logic [DATA_W-1:0]      o_new_score;

    // Shadow copy of the record table and registers
    logic [DATA_W-1:0]  shadow_id    [TABLE_DEPTH];
    logic [DATA_W-1:0]  shadow_score [TABLE_DEPTH];
    logic [COUNT_W-1:0] shadow_count;
    logic [BONUS_W-1:0] shadow_bonus;

    t_res pending_results[$];
    t_row directed_rows[$];
    int   errors;
    logic calm;
    logic gaps_on;

    sorted_table_binary_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_slot        (i_slot),
        .i_entry_id    (i_entry_id),
        .i_entry_score (i_entry_score),
        .i_search_id   (i_search_id),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_found_slot  (o_found_slot),
        .o_new_score   (o_new_score)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAIL sorted_table_binary_search");
        $finish;
    end

    // Apply a load or run the search with bonus on the shadow table
    function automatic t_res search_and_credit(input t_req r);
        t_res   res;
        int     span;
        int     lo;
        int     hi;
        int     mid;
        longint sc;
        res = '0;
        if (r.action == ACT_LOAD) begin
            shadow_id[r.slot]    = r.entry_id;
            shadow_score[r.slot] = r.entry_score;
            return res;
        end
        span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if ($signed(shadow_id[mid]) == $signed(r.search_id)) begin
                sc = longint'($signed(shadow_score[mid])) + longint'(shadow_bonus);
                if (sc > SCORE_TOP)
                    sc = SCORE_TOP;
                shadow_score[mid] = sc[DATA_W-1:0];
                res.found = 1'b1;
                res.slot  = mid[SLOT_W-1:0];
                res.score = shadow_score[mid];
                return res;
            end else if ($signed(shadow_id[mid]) < $signed(r.search_id)) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    // Mostly hits on loaded ids, some near and wild misses, some loads
    function automatic t_req random_request();
        t_req   r;
        int     span;
        int     k;
        int     dice;
        longint lo_b;
        longint hi_b;
        r.action      = ACT_SEARCH;
        r.slot        = SLOT_W'($urandom);
        r.entry_id    = $urandom;
        r.entry_score = $urandom;
        r.search_id   = $urandom;
        span = (shadow_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_count);
        dice = $urandom_range(0, 99);
        if (dice < 20) begin
            r.action = ACT_LOAD;
            k = int'(r.slot);
            if (dice < 14) begin
                // rescore only, keep the order
                r.entry_id = shadow_id[k];
            end else if (dice < 18) begin
                // new id that fits between the neighbors, if there is room
                lo_b = (k == 0) ? longint'($signed(ID_MIN))
                                : longint'($signed(shadow_id[k-1])) + 1;
                hi_b = (k == TABLE_DEPTH - 1) ? longint'($signed(ID_MAX))
                                              : longint'($signed(shadow_id[k+1])) - 1;
                if (lo_b <= hi_b)
                    r.entry_id = DATA_W'(lo_b + (longint'({$urandom}) % (hi_b - lo_b + 1)));
                else
                    r.entry_id = shadow_id[k];
            end
            // otherwise keep the wild id and let the table go unsorted
            if ($urandom_range(0, 9) == 0)
                r.entry_score = ID_MAX - $urandom_range(0, 70000);
        end else if (dice < 85 && span > 0) begin
            r.search_id = shadow_id[$urandom_range(0, span - 1)];
        end else if (dice < 92 && span > 0) begin
            r.search_id = shadow_id[$urandom_range(0, span - 1)]
                        + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        end
        return r;
    endfunction

    function automatic void add_req(input logic act, input logic [SLOT_W-1:0] slot,
                                    input logic [DATA_W-1:0] id, input logic [DATA_W-1:0] sc,
                                    input logic [DATA_W-1:0] key, input logic typed,
                                    input logic f, input logic [SLOT_W-1:0] fs,
                                    input logic [DATA_W-1:0] fsc);
        t_row row;
        row                   = '0;
        row.kind              = ROW_REQ;
        row.req.action        = act;
        row.req.slot          = slot;
        row.req.entry_id      = id;
        row.req.entry_score   = sc;
        row.req.search_id     = key;
        row.typed             = typed;
        row.want.found        = f;
        row.want.slot         = fs;
        row.want.score        = fsc;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    // Hold valid and payload until the request is taken, then log its result
    task automatic push_req(input t_req r, input logic typed, input t_res want);
        t_res predicted;
        @(negedge i_clk);
        i_action      = r.action;
        i_slot        = r.slot;
        i_entry_id    = r.entry_id;
        i_entry_score = r.entry_score;
        i_search_id   = r.search_id;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = search_and_credit(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid for a random burst now and then
    task automatic source_gap();
        int n;
        if (calm || !gaps_on || $urandom_range(0, 3) != 0)
            return;
        n = $urandom_range(1, 12);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Drain the block, then write one register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == CFG_ENTRY_COUNT)
            shadow_count = data[COUNT_W-1:0];
        else
            shadow_bonus = data;
    endtask

    // Result side: stall in random bursts unless in the calm tail
    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 12);
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_ready = 1'b0;
                end
            end
            n = $urandom_range(1, 16);
            repeat (n) begin
                @(negedge i_clk);
                i_out_ready = 1'b1;
            end
        end
    end

    // Compare each delivered result with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no request outstanding: found %0d slot %0d score %0d",
                         $time, o_found, o_found_slot, $signed(o_new_score));
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, o_found);
                    errors++;
                end
                if (o_found_slot !== want.slot) begin
                    $display("%0t: found_slot expected %0d got %0d",
                             $time, want.slot, o_found_slot);
                    errors++;
                end
                if (o_new_score !== want.score) begin
                    $display("%0t: new_score expected %0d got %0d",
                             $time, $signed(want.score), $signed(o_new_score));
                    errors++;
                end
            end
        end
    end

    initial begin
        t_req               r;
        logic [COUNT_W-1:0] cnt;
        logic [BONUS_W-1:0] bon;
        errors        = 0;
        calm          = 1'b0;
        gaps_on       = 1'b1;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_ENTRY_COUNT;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_action      = ACT_LOAD;
        i_slot        = '0;
        i_entry_id    = '0;
        i_entry_score = '0;
        i_search_id   = '0;
        shadow_count  = COUNT_RESET;
        shadow_bonus  = BONUS_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fill every slot with ascending ids, extremes at both ends
        for (int s = 0; s < TABLE_DEPTH; s++) begin
            r.action      = ACT_LOAD;
            r.slot        = s[SLOT_W-1:0];
            r.entry_id    = (s == 0) ? ID_MIN : (s == TABLE_DEPTH - 1) ? ID_MAX :
                            ID_MIN + (s << 24) + ($urandom & 32'h00FF_FFFF);
            r.entry_score = $urandom;
            r.search_id   = $urandom;
            source_gap();
            push_req(r, 1'b0, '0);
        end

        // Directed rows: empty table, extreme ids, saturation, bonus and count extremes
        add_cfg(CFG_ENTRY_COUNT, 16'd0);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 8'd0, 32'd0);
        add_req(ACT_SEARCH, 8'd9, 32'd5, 32'd7, ID_MIN, 1'b1, 1'b0, 8'd0, 32'd0);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b1, 1'b0, 8'd0, 32'd0);
        add_req(ACT_LOAD, 8'd0, ID_MIN, ID_MIN, 32'd0, 1'b1, 1'b0, 8'd0, 32'd0);
        add_req(ACT_LOAD, 8'd255, ID_MAX, 32'h7FFF_FFF0, ID_MAX, 1'b1, 1'b0, 8'd0, 32'd0);
        add_cfg(CFG_ENTRY_COUNT, 16'd256);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MIN, 1'b1, 1'b1, 8'd0, 32'h8000_0064);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b1, 1'b1, 8'd255, ID_MAX);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b1, 1'b1, 8'd255, ID_MAX);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MIN + 1, 1'b1, 1'b0, 8'd0, 32'd0);
        add_cfg(CFG_BONUS_AMOUNT, 16'hFFFF);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MIN, 1'b1, 1'b1, 8'd0, 32'h8001_0063);
        add_cfg(CFG_BONUS_AMOUNT, 16'd0);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MIN, 1'b1, 1'b1, 8'd0, 32'h8001_0063);
        add_cfg(CFG_ENTRY_COUNT, 16'd511);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b1, 1'b1, 8'd255, ID_MAX);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 8'd0, 32'd0);
        add_cfg(CFG_ENTRY_COUNT, 16'd1);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MIN, 1'b1, 1'b1, 8'd0, 32'h8001_0063);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b1, 1'b0, 8'd0, 32'd0);
        add_cfg(CFG_ENTRY_COUNT, 16'd2);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, ID_MAX, 1'b0, 1'b0, 8'd0, 32'd0);
        add_req(ACT_SEARCH, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0, 32'd0);
        add_cfg(CFG_BONUS_AMOUNT, 16'd100);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_reg(directed_rows[i].idx, directed_rows[i].data);
            end else begin
                source_gap();
                push_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // Random phases, each under its own register setting; last one runs calm
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       cnt = 9'd0;
                1:       cnt = 9'd1;
                2:       cnt = 9'd255;
                3:       cnt = 9'd511;
                4:       cnt = 9'd256;
                default: cnt = COUNT_W'($urandom_range(2, 511));
            endcase
            if (p == 0 || p == PHASES - 1)
                cnt = 9'd256;
            case ($urandom_range(0, 4))
                0:       bon = 16'd0;
                1:       bon = 16'hFFFF;
                2:       bon = 16'd100;
                default: bon = BONUS_W'($urandom);
            endcase
            write_reg(CFG_ENTRY_COUNT, {{(CFG_DATA_W - COUNT_W){1'b0}}, cnt});
            write_reg(CFG_BONUS_AMOUNT, bon);
            gaps_on = ($urandom_range(0, 4) != 0);
            calm    = (p == PHASES - 1);
            for (int n = 0; n < PHASE_REQS; n++) begin
                source_gap();
                push_req(random_request(), 1'b0, '0);
            end
        end

        // Let the last results drain
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("PASS sorted_table_binary_search");
        else
            $display("FAIL sorted_table_binary_search");
        $finish;
    end

endmodule
